// File: hw/rtl/hss_pkg.sv
// hss_pkg: shared types and constants of the horspool search trace block
// used by the channel interfaces, controller, datapath and top level
package hss_pkg;

   localparam int BYTE_W     = 8;
   localparam int LEN_W      = 5;
   localparam int POS_W      = 32;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_SEARCH
   } state_type;

   typedef struct packed {
      logic accept;
      logic emit;
      logic search_step;
   } cmd_type;

   typedef struct packed {
      logic align;
      logic cmp_last;
      logic srch_done;
   } status_type;

endpackage

// File: hw/rtl/hss_req_if.sv
// hss_req_if: request channel carrying one text byte per request
// depends on hss_pkg
interface hss_req_if;
   import hss_pkg::*;

   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink (input valid, input text_byte, output ready);
endinterface

// File: hw/rtl/hss_rsp_if.sv
// hss_rsp_if: result channel carrying one compared position per result transfer
// depends on hss_pkg
interface hss_rsp_if;
   import hss_pkg::*;

   logic             valid;
   logic             ready;
   logic [POS_W-1:0] compared_position;
   logic             last_of_run;

   modport source (output valid, output compared_position, output last_of_run, input ready);
   modport sink (input valid, input compared_position, input last_of_run, output ready);
endinterface

// File: hw/rtl/hss_ctrl.sv
// hss_ctrl: sequencer for accept, right-to-left compare and shift search
// depends on hss_pkg; drives commands to hss_dpath and owns the result valid
module hss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  hss_pkg::status_type status,
   output hss_pkg::cmd_type   cmd
);
   import hss_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      out_free  = !rsp_valid_ff || rsp_ready;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.align) state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (status.cmp_last) state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.search_step = 1'b1;
            if (status.srch_done) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      priority if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready)    rsp_valid_in = 1'b0;
      else                   rsp_valid_in = rsp_valid_ff;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: hw/rtl/hss_dpath.sv
// hss_dpath: pattern registers, text window, compare and search shift lines
// depends on hss_pkg; steered by hss_ctrl through cmd_type and status_type
module hss_dpath #(
   parameter int WIN_BYTES = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [hss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hss_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic [hss_pkg::BYTE_W-1:0]      text_byte,
   input  hss_pkg::cmd_type                cmd,
   output hss_pkg::status_type             status,
   output logic [hss_pkg::POS_W-1:0]       compared_position,
   output logic                            last_of_run
);
   import hss_pkg::*;

   localparam int WIN_BITS = BYTE_W * WIN_BYTES;
   localparam int IDX_W    = (WIN_BYTES > 1) ? $clog2(WIN_BYTES) : 1;
   localparam int OFF_W    = LEN_W + 1;

   logic [CSR_DATA_W-1:0] pat_lo_ff, pat_lo_in, pat_hi_ff, pat_hi_in;
   logic [LEN_W-1:0]      len_ff, len_in, bua_ff, bua_in;
   logic [POS_W-1:0]      wsp_ff, wsp_in;
   logic [WIN_BITS-1:0]   win_ff, win_in, win_next;
   logic [WIN_BITS-1:0]   cw_ff, cw_in, pr_ff, pr_in;
   logic [BYTE_W-1:0]     last_ff, last_in;
   logic [IDX_W-1:0]      k_ff, k_in;
   logic [LEN_W-1:0]      sh_ff, sh_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  lor_ff, lor_in;

   logic [2*CSR_DATA_W-1:0] pat_all;
   logic [WIN_BITS-1:0]     pat_vec;
   logic [OFF_W-1:0]        off_cmp, off_srch;
   logic [LEN_W-1:0]        len_wr, shift_amt;
   logic [BYTE_W-1:0]       cw_top, pr_top;
   logic [POS_W:0]          pos_sum, wsp_sum;
   logic [POS_W-1:0]        pos_sat, wsp_sat;
   logic                    len_one, srch_match;

   assign pat_all  = {pat_hi_ff, pat_lo_ff};
   assign pat_vec  = pat_all[WIN_BITS-1:0];
   assign off_cmp  = OFF_W'(WIN_BYTES) - OFF_W'(len_ff);
   assign off_srch = off_cmp + OFF_W'(1);
   assign cw_top   = cw_ff[WIN_BITS-1 -: BYTE_W];
   assign pr_top   = pr_ff[WIN_BITS-1 -: BYTE_W];
   assign len_one  = (len_ff == LEN_W'(1));
   assign win_next = (win_ff >> BYTE_W) | (WIN_BITS'(text_byte) << (WIN_BITS - BYTE_W));

   assign srch_match = (pr_top == last_ff);
   assign shift_amt  = (len_one || !srch_match) ? len_ff : sh_ff;

   assign pos_sum = {1'b0, wsp_ff} + (POS_W + 1)'(k_ff);
   assign pos_sat = pos_sum[POS_W] ? '1 : pos_sum[POS_W-1:0];
   assign wsp_sum = {1'b0, wsp_ff} + (POS_W + 1)'(shift_amt);
   assign wsp_sat = wsp_sum[POS_W] ? '1 : wsp_sum[POS_W-1:0];

   assign status.align     = (bua_ff == LEN_W'(1));
   assign status.cmp_last  = (cw_top != pr_top) || (k_ff == '0);
   assign status.srch_done = len_one || srch_match || (k_ff == '0);

   // length clamp: zero becomes one, above the window size becomes the size
   always_comb begin
      len_wr = csr_wdata[LEN_W-1:0];
      if (len_wr == '0) len_wr = LEN_W'(1);
      if (len_wr > LEN_W'(WIN_BYTES)) len_wr = LEN_W'(WIN_BYTES);
   end

   always_comb begin
      pat_lo_in = pat_lo_ff;
      pat_hi_in = pat_hi_ff;
      len_in    = len_ff;
      win_in    = win_ff;
      bua_in    = bua_ff;
      wsp_in    = wsp_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PATTERN_LOW:  pat_lo_in = csr_wdata;
            CSR_PATTERN_HIGH: pat_hi_in = csr_wdata;
            CSR_PATTERN_LEN: begin
               len_in = len_wr;
               win_in = '0;
               bua_in = len_wr;
               wsp_in = POS_W'(1);
            end
            default: ;
         endcase
      end
      if (cmd.accept) begin
         win_in = win_next;
         if (!status.align) bua_in = bua_ff - LEN_W'(1);
      end
      if (cmd.search_step && status.srch_done) begin
         wsp_in = wsp_sat;
         bua_in = shift_amt;
      end
   end

   always_comb begin
      cw_in   = cw_ff;
      pr_in   = pr_ff;
      last_in = last_ff;
      k_in    = k_ff;
      sh_in   = sh_ff;
      pos_in  = pos_ff;
      lor_in  = lor_ff;
      if (cmd.accept && status.align) begin
         cw_in   = win_next;
         pr_in   = pat_vec << {off_cmp, 3'b000};
         last_in = text_byte;
         k_in    = IDX_W'(len_ff - LEN_W'(1));
      end
      if (cmd.emit) begin
         pos_in = pos_sat;
         lor_in = status.cmp_last;
         cw_in  = cw_ff << BYTE_W;
         pr_in  = pr_ff << BYTE_W;
         k_in   = k_ff - IDX_W'(1);
         if (status.cmp_last) begin
            pr_in = pat_vec << {off_srch, 3'b000};
            k_in  = IDX_W'(len_ff - LEN_W'(2));
            sh_in = LEN_W'(1);
         end
      end
      if (cmd.search_step && !status.srch_done) begin
         pr_in = pr_ff << BYTE_W;
         k_in  = k_ff - IDX_W'(1);
         sh_in = sh_ff + LEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_lo_ff <= '0;
         pat_hi_ff <= '0;
         len_ff    <= LEN_W'(1);
         win_ff    <= '0;
         bua_ff    <= LEN_W'(1);
         wsp_ff    <= POS_W'(1);
      end else begin
         pat_lo_ff <= pat_lo_in;
         pat_hi_ff <= pat_hi_in;
         len_ff    <= len_in;
         win_ff    <= win_in;
         bua_ff    <= bua_in;
         wsp_ff    <= wsp_in;
      end
   end

   always_ff @(posedge clock) begin
      cw_ff   <= cw_in;
      pr_ff   <= pr_in;
      last_ff <= last_in;
      k_ff    <= k_in;
      sh_ff   <= sh_in;
      pos_ff  <= pos_in;
      lor_ff  <= lor_in;
   end

   assign compared_position = pos_ff;
   assign last_of_run       = lor_ff;

endmodule

// File: hw/rtl/horspool_search_trace_core.sv
// horspool_search_trace_core: top level of the horspool search trace block
// depends on hss_pkg, hss_req_if, hss_rsp_if, hss_ctrl and hss_dpath
// a request that completes no alignment is only accepted; one that does is accepted, then
// one result is emitted per compared byte (each held while a result waits), then the shift
// search runs until it finds the next shift; each emitted result is held in a register until taken
// requests are taken only between alignments; sync reset: pattern 0, length 1, position 1
module horspool_search_trace_core #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   hss_req_if.sink                         req_ch,
   hss_rsp_if.source                       rsp_ch,
   input  logic                            csr_wr_en,
   input  logic [hss_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hss_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import hss_pkg::*;

   localparam int LEN_BOUND = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;

   cmd_type    cmd;
   status_type status;

   hss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hss_dpath #(
      .WIN_BYTES (LEN_BOUND)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .text_byte         (req_ch.text_byte),
      .cmd               (cmd),
      .status            (status),
      .compared_position (rsp_ch.compared_position),
      .last_of_run       (rsp_ch.last_of_run)
   );

   // a waiting result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.ready |-> !cmd.emit)
      else $error("result overwritten while stalled");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.accept, cmd.emit, cmd.search_step}) <= 1)
      else $error("more than one command at once");

   a_pos_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.compared_position != '0)
      else $error("zero compared position");

   a_busy_no_req: assert property (@(posedge clock) disable iff (reset)
      cmd.emit || cmd.search_step |-> !req_ch.ready)
      else $error("request taken during an alignment");

endmodule

// File: test/hss_trace_monitor.sv
`timescale 1ns / 1ps
// hss_trace_monitor: watches the request, result and register ports of the
// horspool search trace core, predicts every compared position and checks it
// depends on hss_pkg, hss_req_if and hss_rsp_if
module hss_trace_monitor #(
   parameter int unsigned LEN_MAX = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   hss_req_if                             req_ch,
   hss_rsp_if                             rsp_ch,
   input  logic                           csr_wr_en,
   input  logic [hss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hss_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             pending_count,
   output int                             checked_count
);
   import hss_pkg::*;

   localparam logic [POS_W-1:0] POS_LIMIT = '1;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             last;
   } probe_type;

   probe_type             expected_probes[$];
   logic [CSR_DATA_W-1:0] pattern_low;
   logic [CSR_DATA_W-1:0] pattern_high;
   int unsigned           pattern_len;
   logic [BYTE_W-1:0]     window_bytes[LEN_MAX];
   int unsigned           bytes_to_align;
   logic [POS_W-1:0]      window_pos;

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) $display("%0t mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic logic [BYTE_W-1:0] pattern_byte(input int k);
      return (k < 8) ? pattern_low[8*k +: 8] : pattern_high[8*(k-8) +: 8];
   endfunction

   function automatic logic [POS_W-1:0] advance_pos(input logic [POS_W-1:0] base,
                                                    input int unsigned delta);
      logic [POS_W:0] sum;
      sum = {1'b0, base} + (POS_W+1)'(delta);
      return sum[POS_W] ? POS_LIMIT : sum[POS_W-1:0];
   endfunction

   function automatic void restart_search();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      bytes_to_align = pattern_len;
      window_pos = POS_W'(1);
   endfunction

   function automatic void apply_csr(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] data);
      int unsigned n;
      case (idx)
         CSR_PATTERN_LOW: pattern_low = data;
         CSR_PATTERN_HIGH: pattern_high = data;
         CSR_PATTERN_LEN: begin
            n = 32'(data[LEN_W-1:0]);
            if (n == 0) n = 1;
            if (n > LEN_MAX) n = LEN_MAX;
            pattern_len = n;
            restart_search();
         end
         default: ;
      endcase
   endfunction

   // right-to-left compare at each full alignment, then bad-character skip
   function automatic void predict_alignment(input logic [BYTE_W-1:0] text_byte);
      logic [BYTE_W-1:0] tail;
      int unsigned       skip;
      int                k;
      logic              hit;
      for (int unsigned i = 0; i + 1 < pattern_len; i++) window_bytes[i] = window_bytes[i+1];
      window_bytes[pattern_len-1] = text_byte;
      if (bytes_to_align > 1) begin
         bytes_to_align--;
         return;
      end
      for (k = int'(pattern_len) - 1; k >= 0; k--) begin
         hit = (pattern_byte(k) == window_bytes[k]);
         expected_probes.push_back('{advance_pos(window_pos, unsigned'(k)),
                                     !hit || k == 0});
         if (!hit) break;
      end
      tail = window_bytes[pattern_len-1];
      skip = pattern_len;
      for (k = int'(pattern_len) - 2; k >= 0; k--) begin
         if (pattern_byte(k) == tail) begin
            skip = pattern_len - 1 - unsigned'(k);
            break;
         end
      end
      window_pos = advance_pos(window_pos, skip);
      bytes_to_align = skip;
   endfunction

   task automatic check_probe();
      probe_type want;
      if (expected_probes.size() == 0) begin
         report_mismatch($sformatf("unexpected result at position %0d",
                                   rsp_ch.compared_position));
         return;
      end
      want = expected_probes.pop_front();
      checked_count++;
      if (rsp_ch.compared_position !== want.position)
         report_mismatch($sformatf("compared_position %0d, expected %0d",
                                   rsp_ch.compared_position, want.position));
      if (rsp_ch.last_of_run !== want.last)
         report_mismatch($sformatf("last_of_run %0b at position %0d, expected %0b",
                                   rsp_ch.last_of_run, want.position, want.last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pattern_low = '0;
         pattern_high = '0;
         pattern_len = 1;
         restart_search();
         expected_probes.delete();
         mismatch_count = 0;
         checked_count = 0;
      end else begin
         if (csr_wr_en) apply_csr(csr_index, csr_wdata);
         if (req_ch.valid && req_ch.ready) predict_alignment(req_ch.text_byte);
         if (rsp_ch.valid && rsp_ch.ready) check_probe();
      end
      pending_count = expected_probes.size();
   end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// tb: top of the horspool search trace testbench; feeds text bytes and
// register writes, stalls the result side and gives the verdict
// depends on hss_pkg, hss_req_if, hss_rsp_if, hss_trace_monitor and the core
module tb;
   import hss_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SETTLE_CYCLES = 40;
   localparam int SEARCH_ROUNDS = 12;
   localparam int BYTES_PER_ROUND = 16;
   localparam logic [79:0] OPENING_TEXT = 80'h41_42_41_43_41_42_41_41_43_41;
   localparam logic [127:0] FULL_PATTERN = 128'hFEDC_BA98_7654_3210_0123_4567_89AB_CDEF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    req_idle_pct;
   int                    rsp_idle_pct;
   int                    bytes_sent;
   int                    csr_writes;
   int                    mismatch_count;
   int                    pending_count;
   int                    checked_count;

   hss_req_if req_ch();
   hss_rsp_if rsp_ch();

   horspool_search_trace_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hss_trace_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ch.ready <= !reset && ($urandom_range(99) >= rsp_idle_pct);
   end

   task automatic send_text(input logic [BYTE_W-1:0] value);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.text_byte <= value;
      @(posedge clock);
      while (!(req_ch.valid && req_ch.ready)) @(posedge clock);
      @(negedge clock);
      bytes_sent++;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_writes++;
   endtask

   task automatic csr_release();
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      logic [BYTE_W-1:0]     alphabet[4];
      logic [BYTE_W-1:0]     pattern_text[16];
      logic [CSR_DATA_W-1:0] word_low;
      logic [CSR_DATA_W-1:0] word_high;
      logic [BYTE_W-1:0]     b;
      int unsigned           cur_len;
      int unsigned           round_bytes;
      int unsigned           pick;

      req_ch.valid = 1'b0;
      req_ch.text_byte = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_idle_pct = 27;
      rsp_idle_pct = 50;
      bytes_sent = 0;
      csr_writes = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset defaults: zero pattern of length one
      send_text(8'h00);
      send_text(8'hFF);

      // unmapped index ignored, length taken from the low bits
      wait_idle();
      csr_write(CSR_UNMAPPED, '1);
      csr_write(CSR_PATTERN_LOW, 64'hFFFF_FFFF_4341_4241);
      csr_write(CSR_PATTERN_HIGH, 64'h0);
      csr_write(CSR_PATTERN_LEN, 64'hFFFF_FFFF_FFFF_FFE4);
      csr_release();
      for (int i = 9; i >= 0; i--) send_text(OPENING_TEXT[8*i +: 8]);

      // zero length clamps to one and restarts with bytes pending
      wait_idle();
      csr_write(CSR_PATTERN_LEN, 64'd0);
      csr_release();
      send_text(8'h41);

      // oversize length clamps to sixteen, full match
      wait_idle();
      csr_write(CSR_PATTERN_LOW, FULL_PATTERN[63:0]);
      csr_write(CSR_PATTERN_HIGH, FULL_PATTERN[127:64]);
      csr_write(CSR_PATTERN_LEN, 64'd31);
      csr_release();
      for (int i = 0; i < 16; i++) send_text(FULL_PATTERN[8*i +: 8]);

      cur_len = 16;
      for (int round = 0; round < SEARCH_ROUNDS; round++) begin
         case (round * 3 / SEARCH_ROUNDS)
            0: begin
               req_idle_pct = 27;
               rsp_idle_pct = 50;
            end
            1: begin
               req_idle_pct = 50;
               rsp_idle_pct = 27;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         wait_idle();
         foreach (alphabet[i]) alphabet[i] = BYTE_W'($urandom_range(255));
         foreach (pattern_text[i]) begin
            pattern_text[i] = ($urandom_range(3) == 0) ? BYTE_W'($urandom_range(255))
                                                       : alphabet[$urandom_range(3)];
            if (i < 8) word_low[8*i +: 8] = pattern_text[i];
            else word_high[8*(i-8) +: 8] = pattern_text[i];
         end
         csr_write(CSR_PATTERN_LOW, word_low);
         csr_write(CSR_PATTERN_HIGH, word_high);
         // every third round swaps the pattern but keeps the search going
         if (round % 3 != 2) begin
            cur_len = (round % 4 == 0) ? 16 : (round % 4 == 1) ? 1 : $urandom_range(2, 15);
            csr_write(CSR_PATTERN_LEN,
                      ({$urandom, $urandom} & ~64'h1F) | CSR_DATA_W'(cur_len));
         end
         csr_release();

         round_bytes = 0;
         while (round_bytes < BYTES_PER_ROUND) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
               for (int k = 0; k < int'(cur_len); k++) begin
                  b = pattern_text[k];
                  if ($urandom_range(9) == 0) b = BYTE_W'($urandom_range(255));
                  send_text(b);
               end
               round_bytes += cur_len;
            end else begin
               send_text(pick < 85 ? alphabet[$urandom_range(3)] : BYTE_W'($urandom_range(255)));
               round_bytes++;
            end
         end
      end

      wait_idle();
      $display("sent %0d text bytes and %0d register writes, checked %0d compared positions",
               bytes_sent, csr_writes, checked_count);
      $display("lengths one to sixteen, clamped lengths, pattern swaps mid-search, mixed stalls");
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
